### rtl/lfbs_pkg.sv
// Shared types, codes and reset values for the link failover backoff sequencer.
package lfbs_pkg;

	localparam int unsigned TIME_W = 32;

	typedef logic [1:0] profile_t;
	localparam profile_t PROF_NONE    = 2'd0;
	localparam profile_t PROF_PRIMARY = 2'd1;
	localparam profile_t PROF_BACKUP1 = 2'd2;
	localparam profile_t PROF_BACKUP2 = 2'd3;

	typedef enum logic [1:0] {
		OP_UPDATE  = 2'd0,
		OP_NOTE    = 2'd1,
		OP_RESET   = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_START  = 2'd1,
		ACT_FAILED = 2'd2,
		ACT_RSVD   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_ATTEMPT   = 2'd1,
		PH_CONNECTED = 2'd2,
		PH_WAITING   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_PRIMARY_EN = 3'd0,
		REG_BACKUP1_EN = 3'd1,
		REG_BACKUP2_EN = 3'd2,
		REG_TIMEOUT    = 3'd3,
		REG_INIT_BKOFF = 3'd4,
		REG_MAX_BKOFF  = 3'd5
	} cfg_reg_t;

	localparam logic [TIME_W-1:0] RST_TIMEOUT    = 32'd10000;
	localparam logic [TIME_W-1:0] RST_INIT_BKOFF = 32'd1000;
	localparam logic [TIME_W-1:0] RST_MAX_BKOFF  = 32'd60000;

	typedef struct packed {
		profile_t          reported_profile;
		logic              link_up;
		logic [TIME_W-1:0] time_now;
		opcode_t           opcode;
	} in_item_t;

	typedef struct packed {
		profile_t          last_good;
		phase_t            phase_now;
		logic [TIME_W-1:0] retry_delay;
		profile_t          target_profile;
		action_t           action;
	} out_item_t;

	// en[0] primary, en[1] backup one, en[2] backup two
	function automatic logic is_avail(input profile_t p, input logic [2:0] en);
		logic r;
		case (p)
			PROF_PRIMARY: r = en[0];
			PROF_BACKUP1: r = en[1];
			PROF_BACKUP2: r = en[2];
			default:      r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

### rtl/lfbs_core.sv
// Sequencer state and the combinational step that turns one event into one result.
module lfbs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                step_en,
	input  lfbs_pkg::in_item_t  item,
	output lfbs_pkg::out_item_t result
);
	import lfbs_pkg::*;

	// configuration
	logic [2:0]        en_q;
	logic [TIME_W-1:0] timeout_q, init_bkoff_q, max_bkoff_q;

	// sequencer state
	phase_t            phase_q, phase_d;
	profile_t          order_q [3];
	profile_t          order_d [3];
	logic [1:0]        size_q, size_d;
	logic [1:0]        pos_q, pos_d;
	profile_t          active_q, active_d;
	profile_t          last_q, last_d;
	logic [TIME_W-1:0] start_q, start_d;
	logic [TIME_W-1:0] next_q, next_d;
	logic [TIME_W-1:0] bkoff_q, bkoff_d;

	logic [2:0]        en_new;
	logic [TIME_W-1:0] wait_diff, run_diff, bkoff_sat, bkoff_lim;
	logic [TIME_W:0]   bkoff_x2;
	logic [1:0]        pos_inc;
	profile_t          pos_prof;
	profile_t          build0, build1, build2;

	assign wait_diff = item.time_now - next_q;
	assign run_diff  = item.time_now - start_q;
	assign bkoff_x2  = {bkoff_q, 1'b0};
	assign bkoff_sat = bkoff_x2[TIME_W] ? {TIME_W{1'b1}} : bkoff_x2[TIME_W-1:0];
	assign bkoff_lim = (bkoff_sat > max_bkoff_q) ? max_bkoff_q : bkoff_sat;
	assign pos_inc   = (pos_q < 2'd3) ? pos_q + 2'd1 : pos_q;

	// priority compaction of the enabled profiles
	assign build0 = en_q[0] ? PROF_PRIMARY : (en_q[1] ? PROF_BACKUP1 :
	                (en_q[2] ? PROF_BACKUP2 : PROF_NONE));
	assign build1 = en_q[0] ? (en_q[1] ? PROF_BACKUP1 : (en_q[2] ? PROF_BACKUP2 : PROF_NONE))
	                        : ((en_q[1] && en_q[2]) ? PROF_BACKUP2 : PROF_NONE);
	assign build2 = (&en_q) ? PROF_BACKUP2 : PROF_NONE;

	always_comb begin
		case (pos_inc)
			2'd0:    pos_prof = order_q[0];
			2'd1:    pos_prof = order_q[1];
			2'd2:    pos_prof = order_q[2];
			default: pos_prof = PROF_NONE;
		endcase
	end

	// new enable vector for an availability write
	always_comb begin
		en_new = en_q;
		case (cfg_index)
			REG_PRIMARY_EN: en_new[0] = cfg_wdata[0];
			REG_BACKUP1_EN: en_new[1] = cfg_wdata[0];
			REG_BACKUP2_EN: en_new[2] = cfg_wdata[0];
			default: ;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		order_d  = order_q;
		size_d   = size_q;
		pos_d    = pos_q;
		active_d = active_q;
		last_d   = last_q;
		start_d  = start_q;
		next_d   = next_q;
		bkoff_d  = bkoff_q;
		result   = '0;
		result.action = ACT_NONE;

		if (step_en) begin
			case (item.opcode)
				OP_UPDATE: begin
					if (item.link_up) begin
						if (is_avail(active_q, en_q))
							last_d = active_q;
						phase_d = PH_CONNECTED;
						bkoff_d = init_bkoff_q;
					end else if (en_q == 3'b000) begin
						active_d = PROF_NONE;
						phase_d  = PH_IDLE;
					end else if (phase_q == PH_CONNECTED || phase_q == PH_IDLE ||
					             (phase_q == PH_WAITING && !wait_diff[TIME_W-1])) begin
						// fresh round, launch its first profile
						order_d[0] = build0;
						order_d[1] = build1;
						order_d[2] = build2;
						size_d     = 2'($countones(en_q));
						pos_d      = 2'd0;
						active_d   = build0;
						start_d    = item.time_now;
						phase_d    = PH_ATTEMPT;
						result.action         = ACT_START;
						result.target_profile = build0;
					end else if (phase_q == PH_ATTEMPT && run_diff >= timeout_q) begin
						pos_d = pos_inc;
						if (pos_inc < size_q) begin
							active_d = pos_prof;
							start_d  = item.time_now;
							phase_d  = PH_ATTEMPT;
							if (pos_prof != PROF_NONE) begin
								result.action         = ACT_START;
								result.target_profile = pos_prof;
							end
						end else begin
							// round exhausted: report and back off
							result.action      = ACT_FAILED;
							result.retry_delay = bkoff_q;
							next_d   = item.time_now + bkoff_q;
							bkoff_d  = bkoff_lim;
							active_d = PROF_NONE;
							phase_d  = PH_WAITING;
						end
					end
				end
				OP_NOTE: begin
					if (is_avail(item.reported_profile, en_q)) begin
						active_d = item.reported_profile;
						last_d   = item.reported_profile;
						phase_d  = PH_CONNECTED;
						bkoff_d  = init_bkoff_q;
					end
				end
				OP_RESET: begin
					phase_d  = PH_IDLE;
					size_d   = 2'd0;
					pos_d    = 2'd0;
					active_d = PROF_NONE;
					start_d  = '0;
					next_d   = '0;
					bkoff_d  = init_bkoff_q;
				end
				default: ;
			endcase
		end else if (cfg_we && (cfg_index == REG_PRIMARY_EN || cfg_index == REG_BACKUP1_EN ||
		                        cfg_index == REG_BACKUP2_EN)) begin
			// drop profiles that are no longer available
			if (!is_avail(last_q, en_new))
				last_d = PROF_NONE;
			if (!is_avail(active_q, en_new)) begin
				active_d = PROF_NONE;
				phase_d  = PH_IDLE;
			end
		end

		result.phase_now = phase_d;
		result.last_good = last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= 3'b000;
			timeout_q    <= RST_TIMEOUT;
			init_bkoff_q <= RST_INIT_BKOFF;
			max_bkoff_q  <= RST_MAX_BKOFF;
			phase_q      <= PH_IDLE;
			order_q      <= '{PROF_NONE, PROF_NONE, PROF_NONE};
			size_q       <= 2'd0;
			pos_q        <= 2'd0;
			active_q     <= PROF_NONE;
			last_q       <= PROF_NONE;
			start_q      <= '0;
			next_q       <= '0;
			bkoff_q      <= RST_INIT_BKOFF;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PRIMARY_EN,
					REG_BACKUP1_EN,
					REG_BACKUP2_EN: en_q         <= en_new;
					REG_TIMEOUT:    timeout_q    <= cfg_wdata;
					REG_INIT_BKOFF: init_bkoff_q <= cfg_wdata;
					REG_MAX_BKOFF:  max_bkoff_q  <= cfg_wdata;
					default: ;
				endcase
			end
			phase_q  <= phase_d;
			order_q  <= order_d;
			size_q   <= size_d;
			pos_q    <= pos_d;
			active_q <= active_d;
			last_q   <= last_d;
			start_q  <= start_d;
			next_q   <= next_d;
			bkoff_q  <= bkoff_d;
		end
	end

	a_attempt_has_profile: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ATTEMPT |-> active_q != PROF_NONE)
		else $error("attempt phase without an active profile");

	a_round_size: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= 2'd3 && size_q <= 2'($countones(en_q)) + 2'd0 || phase_q != PH_ATTEMPT
		|| size_q <= 2'd3)
		else $error("round size out of range");

	a_failed_waits: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.action == ACT_FAILED |=> phase_q == PH_WAITING && active_q == PROF_NONE)
		else $error("failed round did not enter waiting");

	a_start_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.action == ACT_START |=>
		active_q == $past(result.target_profile) && phase_q == PH_ATTEMPT)
		else $error("started profile not recorded as active");

endmodule

### rtl/lfbs_out_buf.sv
// Two-word result buffer that lets the step keep running while the receiver stalls.
module lfbs_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lfbs_pkg::out_item_t push_data,
	output logic                full,
	output logic                out_valid,
	input  logic                out_ready,
	output lfbs_pkg::out_item_t out_data
);
	import lfbs_pkg::*;

	out_item_t  mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into full buffer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2 && ((cnt_q == 2'd1) == (wr_q != rd_q)))
		else $error("buffer pointers and count disagree");

	a_pop_pushes_order: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && cnt_q == 2'd0 |=> out_valid && out_data == $past(push_data))
		else $error("word into empty buffer not presented");

endmodule

### rtl/link_failover_backoff_sequencer_top.sv
// Top level of the link failover backoff sequencer: stream ports and config port.
//
// Usage:
//   Events enter on the s_ stream; one result word leaves on the m_ stream for
//   every accepted event, in order. An event is taken when s_tvalid and
//   s_tready are both high at a rising edge of clk.
//   Configuration registers (0..2 profile enables, 3 attempt timeout,
//   4 initial backoff, 5 maximum backoff) are written through cfg_we /
//   cfg_index / cfg_wdata while no event is in flight; other indexes are
//   ignored. Writing an enable drops an active or last-good profile that has
//   become unavailable.
// Step and throughput:
//   The whole step is compare/add/shift logic with no register in it; the result word
//   is written into the result buffer and shown on m_ from there. One event per cycle
//   is sustained while the receiver keeps m_tready high.
// Stall behavior:
//   Results sit in a two-word buffer. Input stays ready while at least one
//   slot is free, so one more event is taken after the receiver stops; after
//   that s_tready drops until a word drains.
// Reset:
//   arst_n clears all sequencer state to idle, disables all profiles, loads
//   the register reset values and empties the result buffer.
module link_failover_backoff_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] time_now, [32] link_up, [34:33] reported_profile
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] target_profile, [33:2] retry_delay,
	                               // [35:34] phase_now, [37:36] last_good
	output logic [1:0]  m_tuser    // [1:0] action
);
	import lfbs_pkg::*;

	in_item_t  item;
	out_item_t step_res, buf_res;
	logic      step_en, buf_full;

	// unpack the incoming word
	assign item.opcode           = opcode_t'(s_tuser);
	assign item.time_now         = s_tdata[31:0];
	assign item.link_up          = s_tdata[32];
	assign item.reported_profile = s_tdata[34:33];

	assign s_tready = !buf_full;
	assign step_en  = s_tvalid && s_tready;

	lfbs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step_en   (step_en),
		.item      (item),
		.result    (step_res)
	);

	lfbs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step_en),
		.push_data (step_res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (buf_res)
	);

	// pack the outgoing word, zero fill to whole bytes
	assign m_tuser = buf_res.action;
	assign m_tdata = {2'b00, buf_res.last_good, buf_res.phase_now,
	                  buf_res.retry_delay, buf_res.target_profile};

endmodule
